// ===== sv/khsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package khsr_pkg;

    localparam int HASH_BITS = 12;
    localparam int OWNER_BITS = 8;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] SLOT_MASK = 16'h0FFF;
    localparam logic [7:0] BRACE_OPEN = 8'h7B;
    localparam logic [7:0] BRACE_CLOSE = 8'h7D;

    typedef enum logic [1:0] {
        ACT_KEY    = 2'd0,
        ACT_ASSIGN = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_PRE  = 2'd0,
        PH_TAG  = 2'd1,
        PH_DONE = 2'd2
    } t_tag_phase;

    // one accepted key word toward the hash unit
    typedef struct packed {
        logic       step;
        logic [7:0] kbyte;
        logic       last;
    } t_key_step;

    // CRC16 XMODEM, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/khsr_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

module khsr_hash (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire khsr_pkg::t_key_step           i_key,
    output logic [khsr_pkg::HASH_BITS-1:0]     o_slot
);
    import khsr_pkg::*;

    logic [15:0] r_whole, n_whole;
    logic [15:0] r_tag, n_tag;
    logic        r_nonempty, n_nonempty;
    t_tag_phase  r_phase, n_phase;
    logic [15:0] pick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whole    <= '0;
            r_tag      <= '0;
            r_nonempty <= 1'b0;
            r_phase    <= PH_PRE;
        end else begin
            r_whole    <= n_whole;
            r_tag      <= n_tag;
            r_nonempty <= n_nonempty;
            r_phase    <= n_phase;
        end
    end

    always_comb begin
        n_whole    = r_whole;
        n_tag      = r_tag;
        n_nonempty = r_nonempty;
        n_phase    = r_phase;
        if (i_key.step) begin
            n_whole = crc16_byte(r_whole, i_key.kbyte);
            unique case (r_phase)
                PH_PRE: begin
                    if (i_key.kbyte == BRACE_OPEN) n_phase = PH_TAG;
                end
                PH_TAG: begin
                    if (i_key.kbyte == BRACE_CLOSE) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_tag      = crc16_byte(r_tag, i_key.kbyte);
                        n_nonempty = 1'b1;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_PRE;
                end
            endcase
        end
        // tag wins only when closed and non-empty
        pick   = (n_phase == PH_DONE && n_nonempty) ? n_tag : n_whole;
        o_slot = HASH_BITS'(pick & SLOT_MASK);
        if (i_key.step && i_key.last) begin
            n_whole    = '0;
            n_tag      = '0;
            n_nonempty = 1'b0;
            n_phase    = PH_PRE;
        end
    end

endmodule

`default_nettype wire

// ===== sv/khsr_slot_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module khsr_slot_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]              o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) mem[i_wr_addr] <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/key_hash_slot_router.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Key hash slot router.
// Input channel (i_in_valid / o_in_ready): one word per cycle while ready.
// Action key carries one key byte; i_last_byte closes the key. Assign writes
// a node id into a slot of the 4096-entry slot table, clear empties a slot;
// action 3 is dropped. Only the last byte of a key produces an output word.
// Output channel (o_out_valid / i_out_ready): hash slot (CRC16 XMODEM of the
// hash tag or of the whole key, low 12 bits), owner node and no-owner flag.
// Path: an accepted last byte enters the read stage (the synchronous read of
// the slot table), then moves on to the output register when that is free.
// Throughput: one word per cycle when not stalled, set by the CRC byte update
// and one table access per word (write port for assign/clear, read port for
// lookups). A table write is visible to any lookup accepted after it.
// Reset: the key state clears at once; the slot table is then cleared entry
// by entry over all SLOT_COUNT (4096) slots, during which o_in_ready stays low.
// Stall: the output register and the read stage hold two results; with both
// full and i_out_ready low, o_in_ready drops until the receiver takes one.

module key_hash_slot_router #(
    parameter int SLOT_COUNT = 4096,
    parameter int NODE_BITS  = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [1:0]                       i_action,
    input  wire logic [7:0]                       i_key_byte,
    input  wire logic                             i_last_byte,
    input  wire logic [11:0]                      i_slot_index,
    input  wire logic [7:0]                       i_node_number,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [khsr_pkg::HASH_BITS-1:0]        o_hash_slot,
    output logic [khsr_pkg::OWNER_BITS-1:0]       o_owner_node,
    output logic                                  o_no_owner
);
    import khsr_pkg::*;

    localparam int SLOT_BITS = $clog2(SLOT_COUNT);
    localparam int ENTRY_BITS = NODE_BITS + 1;

    t_action                 action;
    logic                    in_acc;
    logic                    lookup;
    logic                    adv1;
    t_key_step               key;
    logic [HASH_BITS-1:0]    calc_slot;

    logic                    wr_en;
    logic [SLOT_BITS-1:0]    wr_addr;
    logic [ENTRY_BITS-1:0]   wr_data;
    logic [ENTRY_BITS-1:0]   rd_data;
    logic [NODE_BITS+7:0]    node_ext;
    logic [NODE_BITS+7:0]    owner_ext;

    logic                    r_clearing, n_clearing;
    logic [SLOT_BITS-1:0]    r_clr_addr, n_clr_addr;
    logic                    r_s1_vld, n_s1_vld;
    logic [HASH_BITS-1:0]    r_s1_slot;
    logic                    r_out_vld, n_out_vld;
    logic [HASH_BITS-1:0]    r_out_slot;
    logic [OWNER_BITS-1:0]   r_out_node;
    logic                    r_out_none;

    assign action     = t_action'(i_action);
    assign adv1       = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_clearing && (!r_s1_vld || adv1);
    assign in_acc     = i_in_valid && o_in_ready;
    assign lookup     = in_acc && action == ACT_KEY && i_last_byte;

    assign key.step  = in_acc && action == ACT_KEY;
    assign key.kbyte = i_key_byte;
    assign key.last  = i_last_byte;

    khsr_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key),
        .o_slot  (calc_slot)
    );

    // node id kept to NODE_BITS; read back widened or cut to the port
    assign node_ext  = {NODE_BITS'(0), i_node_number};
    assign owner_ext = {8'h00, rd_data[NODE_BITS-1:0]};

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = SLOT_BITS'(i_slot_index);
        wr_data = '0;
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
        end else if (in_acc && action == ACT_ASSIGN) begin
            wr_en   = 1'b1;
            wr_data = {1'b1, node_ext[NODE_BITS-1:0]};
        end else if (in_acc && action == ACT_CLEAR) begin
            wr_en   = 1'b1;
        end
    end

    khsr_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (ENTRY_BITS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (lookup),
        .i_rd_addr (SLOT_BITS'(calc_slot)),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == SLOT_BITS'(SLOT_COUNT - 1)) n_clearing = 1'b0;
        end
        n_s1_vld  = lookup ? 1'b1 : (adv1 ? 1'b0 : r_s1_vld);
        n_out_vld = adv1 ? r_s1_vld : r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
            r_s1_vld   <= n_s1_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lookup) r_s1_slot <= calc_slot;
        if (adv1 && r_s1_vld) begin
            r_out_slot <= r_s1_slot;
            r_out_node <= rd_data[NODE_BITS] ? owner_ext[OWNER_BITS-1:0] : '0;
            r_out_none <= !rd_data[NODE_BITS];
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_hash_slot  = r_out_slot;
    assign o_owner_node = r_out_node;
    assign o_no_owner   = r_out_none;

    a_no_accept_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_acc)
        else $error("word accepted during table clear");

    a_s1_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !adv1) |-> !lookup)
        else $error("lookup overwrote pending read stage");

    a_out_from_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_s1_vld))
        else $error("output word without a table read");

    a_no_write_on_lookup : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lookup |-> !wr_en)
        else $error("table write and lookup in one cycle");

endmodule

`default_nettype wire

// ===== bench/tb_key_hash_slot_router.sv =====
`timescale 1ns / 1ps

module tb_key_hash_slot_router;

    import khsr_pkg::*;

    localparam int SLOT_COUNT = 4096;
    localparam int RANDOM_WORDS = 800;
    localparam int PRINT_CAP = 100;

    typedef logic [7:0] t_bytes[$];

    // running key summary: whole-key CRC, tag CRC and brace tracking
    typedef struct packed {
        logic [15:0] whole;
        logic [15:0] tag;
        t_tag_phase  phase;
        logic        tag_seen;
    } t_key_sum;

    typedef struct packed {
        logic [HASH_BITS-1:0]  slot;
        logic [OWNER_BITS-1:0] owner;
        logic                  none;
    } t_lookup;

    localparam t_key_sum KEY_IDLE = '{16'h0000, 16'h0000, PH_PRE, 1'b0};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_action               i_action;
    logic [7:0]            i_key_byte;
    logic                  i_last_byte;
    logic [11:0]           i_slot_index;
    logic [7:0]            i_node_number;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [HASH_BITS-1:0]  o_hash_slot;
    logic [OWNER_BITS-1:0] o_owner_node;
    logic                  o_no_owner;

    t_key_sum              key_state;
    logic                  slot_used [SLOT_COUNT];
    logic [OWNER_BITS-1:0] slot_owner [SLOT_COUNT];
    t_lookup               pending_lookups[$];

    int   mismatch_count;
    int   words_sent;
    logic feed_gaps_on;
    logic drain_stalls_on;

    key_hash_slot_router i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_key_byte    (i_key_byte),
        .i_last_byte   (i_last_byte),
        .i_slot_index  (i_slot_index),
        .i_node_number (i_node_number),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hash_slot   (o_hash_slot),
        .o_owner_node  (o_owner_node),
        .o_no_owner    (o_no_owner)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // XMODEM CRC, shifted one data bit at a time, MSB first
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ data[k];
            r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic t_key_sum key_advance(input t_key_sum s, input logic [7:0] b);
        t_key_sum n;
        n = s;
        n.whole = crc_step(s.whole, b);
        case (s.phase)
            PH_PRE: begin
                if (b == BRACE_OPEN) n.phase = PH_TAG;
            end
            PH_TAG: begin
                if (b == BRACE_CLOSE) begin
                    n.phase = PH_DONE;
                end else begin
                    n.tag = crc_step(s.tag, b);
                    n.tag_seen = 1'b1;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // closed non-empty tag wins, else the whole key
    function automatic logic [HASH_BITS-1:0] key_pick(input t_key_sum s);
        logic [15:0] crc;
        crc = (s.phase == PH_DONE && s.tag_seen) ? s.tag : s.whole;
        return HASH_BITS'(crc & SLOT_MASK);
    endfunction

    function automatic logic [HASH_BITS-1:0] key_slot(input t_bytes kb);
        t_key_sum s;
        s = KEY_IDLE;
        foreach (kb[i]) s = key_advance(s, kb[i]);
        return key_pick(s);
    endfunction

    function automatic void route_word(input t_action act, input logic [7:0] kb,
                                       input logic lst, input logic [11:0] idx,
                                       input logic [7:0] node);
        t_lookup e;
        case (act)
            ACT_ASSIGN: begin
                slot_used[idx] = 1'b1;
                slot_owner[idx] = node;
            end
            ACT_CLEAR: begin
                slot_used[idx] = 1'b0;
                slot_owner[idx] = '0;
            end
            ACT_KEY: begin
                key_state = key_advance(key_state, kb);
                if (lst) begin
                    e.slot = key_pick(key_state);
                    e.none = !slot_used[e.slot];
                    e.owner = slot_used[e.slot] ? slot_owner[e.slot] : '0;
                    pending_lookups.push_back(e);
                    key_state = KEY_IDLE;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) $display("mismatch @%0t: %s", $time, what);
    endtask

    task automatic check_lookup();
        t_lookup e;
        if (pending_lookups.size() == 0) begin
            flag_mismatch($sformatf("unexpected word slot=%0d", o_hash_slot));
        end else begin
            e = pending_lookups.pop_front();
            if (o_hash_slot !== e.slot)
                flag_mismatch($sformatf("hash_slot %0d, want %0d", o_hash_slot, e.slot));
            if (o_owner_node !== e.owner)
                flag_mismatch($sformatf("owner_node %0d, want %0d (slot %0d)",
                                        o_owner_node, e.owner, e.slot));
            if (o_no_owner !== e.none)
                flag_mismatch($sformatf("no_owner %0b, want %0b (slot %0d)",
                                        o_no_owner, e.none, e.slot));
        end
    endtask

    // called at a clock edge; returns at the edge that takes the word
    task automatic send_word(input t_action act, input logic [7:0] kb, input logic lst,
                             input logic [11:0] idx, input logic [7:0] node);
        int gap;
        gap = feed_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_key_byte <= kb;
        i_last_byte <= lst;
        i_slot_index <= idx;
        i_node_number <= node;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        route_word(act, kb, lst, idx, node);
        if (act != ACT_NOP) words_sent++;
    endtask

    task automatic send_noise_word();
        send_word(t_action'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
                  12'($urandom), 8'($urandom));
    endtask

    task automatic send_key(input t_bytes kb, input int mix_pct);
        for (int i = 0; i < kb.size(); i++) begin
            if (i > 0 && $urandom_range(0, 99) < mix_pct) send_noise_word();
            send_word(ACT_KEY, kb[i], i == kb.size() - 1, 12'($urandom), 8'($urandom));
        end
    endtask

    task automatic send_text(input string s);
        t_bytes kb;
        for (int i = 0; i < s.len(); i++) kb.push_back(s[i]);
        send_key(kb, 0);
    endtask

    task automatic test_empty_table();
        t_bytes kb;
        kb = '{8'h00};
        send_key(kb, 0);
        kb = '{8'hFF};
        send_key(kb, 0);
    endtask

    task automatic test_slot_updates();
        t_bytes      kb;
        logic [11:0] s;
        kb = '{8'h41};
        s = key_slot(kb);
        send_word(ACT_ASSIGN, 8'h00, 1'b0, s, 8'hFF);
        send_key(kb, 0);
        // overwrite with node 0: still owned
        send_word(ACT_ASSIGN, 8'hFF, 1'b1, s, 8'h00);
        send_key(kb, 0);
        send_word(ACT_CLEAR, 8'h00, 1'b0, s, 8'hFF);
        send_key(kb, 0);
        send_word(ACT_CLEAR, 8'h7B, 1'b1, s, 8'h00);
        send_word(ACT_ASSIGN, 8'h00, 1'b0, 12'hFFF, 8'h5A);
        send_word(ACT_CLEAR, 8'hFF, 1'b1, 12'h000, 8'hA5);
    endtask

    task automatic test_hash_tags();
        send_text("{a}");
        send_text("{}b");
        send_text("{a");
        send_text("{}{c}");
    endtask

    // table words and dropped words in the middle of a key
    task automatic test_mid_key_writes();
        t_bytes      kb;
        logic [11:0] s;
        kb = '{BRACE_OPEN, 8'h62, BRACE_CLOSE};
        s = key_slot(kb);
        send_word(ACT_KEY, BRACE_OPEN, 1'b0, 12'h000, 8'h00);
        send_word(ACT_ASSIGN, 8'hA5, 1'b1, s, 8'hC3);
        send_word(ACT_KEY, 8'h62, 1'b0, 12'hFFF, 8'hFF);
        send_word(ACT_NOP, BRACE_CLOSE, 1'b1, s, 8'h11);
        send_word(ACT_KEY, BRACE_CLOSE, 1'b1, 12'h555, 8'h00);
    endtask

    task automatic test_random_traffic();
        int          target;
        int          len;
        t_bytes      kb;
        logic [11:0] s;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            if ($urandom_range(0, 39) == 0) begin
                feed_gaps_on = ($urandom_range(0, 3) != 0);
                drain_stalls_on = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 9))
                0: begin
                    send_noise_word();
                end
                default: begin
                    kb.delete();
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                    repeat (len) begin
                        case ($urandom_range(0, 9))
                            0: kb.push_back(BRACE_OPEN);
                            1: kb.push_back(BRACE_CLOSE);
                            default: kb.push_back(8'($urandom));
                        endcase
                    end
                    // aim table writes at the key's own slot so lookups hit
                    s = key_slot(kb);
                    case ($urandom_range(0, 3))
                        0: send_word(ACT_ASSIGN, 8'($urandom), 1'($urandom), s, 8'($urandom));
                        1: send_word(ACT_CLEAR, 8'($urandom), 1'($urandom), s, 8'($urandom));
                        default: ;
                    endcase
                    send_key(kb, 10);
                end
            endcase
        end
    endtask

    initial begin : drain_side
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = drain_stalls_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            check_lookup();
        end
    end

    initial begin
        mismatch_count = 0;
        words_sent = 0;
        feed_gaps_on = 1'b1;
        drain_stalls_on = 1'b1;
        key_state = KEY_IDLE;
        foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_owner[i] = '0;
        end
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_action <= ACT_NOP;
        i_key_byte <= '0;
        i_last_byte <= 1'b0;
        i_slot_index <= '0;
        i_node_number <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_slot_updates();
        test_hash_tags();
        test_mid_key_writes();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
